>>> rtl/urbq_pkg.sv
`default_nettype none

package urbq_pkg;

    // Operation codes carried in the input tuser field.
    typedef enum logic [2:0] {
        OP_RX_BYTE   = 3'd0,
        OP_APP_READ  = 3'd1,
        OP_APP_WRITE = 3'd2,
        OP_TX_READY  = 3'd3,
        OP_CLR_STATS = 3'd4
    } t_op;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CNT_W  = 32;
    localparam int unsigned OUT_TDATA_W = 136;

    // Pointer/level updates applied to one ring in the processing cycle.
    typedef struct packed {
        logic push;
        logic pop;
    } t_ring_ctl;

    typedef struct packed {
        logic empty;
        logic full;
    } t_ring_sts;

    // Events that move the statistics counters.
    typedef struct packed {
        logic rx;
        logic drop;
        logic sent;
        logic clear;
    } t_stat_ev;

endpackage

`default_nettype wire

>>> rtl/urbq_ring.sv
`default_nettype none

module urbq_ring
    import urbq_pkg::*;
#(
    parameter int unsigned DEPTH = 256
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_rd_en,
    input  wire t_ring_ctl         i_ctl,
    input  wire logic [BYTE_W-1:0] i_wr_data,
    output t_ring_sts              o_sts,
    output logic [BYTE_W-1:0]      o_rd_data,
    output logic [7:0]             o_level
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned LW = (PW > 8) ? PW : 8;
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [PW-1:0]     r_head, r_tail, r_count;
    logic [PW-1:0]     n_head, n_tail, n_count;
    logic [BYTE_W-1:0] r_mem [DEPTH];
    logic [BYTE_W-1:0] r_rd_data, r_byp_data;
    logic              r_byp;
    logic [LW-1:0]     w_level;

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        if (i_ctl.push) begin
            n_head = (r_head == LAST) ? '0 : r_head + 1'b1;
        end
        if (i_ctl.pop) begin
            n_tail = (r_tail == LAST) ? '0 : r_tail + 1'b1;
        end
        unique case ({i_ctl.push, i_ctl.pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    // Read the entry the next item will see; same-cycle write is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_head] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data  <= r_mem[n_tail];
            r_byp      <= i_ctl.push && (r_head == n_tail);
            r_byp_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rd_data;
    assign o_sts.empty = (r_count == '0);
    assign o_sts.full  = (r_count == LAST);
    assign w_level = LW'(r_count);
    assign o_level = w_level[7:0];

    a_count_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) == (r_head == r_tail))
        else $error("ring count disagrees with pointers");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.push |-> !o_sts.full)
        else $error("push into full ring");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.pop |-> !o_sts.empty)
        else $error("pop from empty ring");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.push && !i_ctl.pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("push did not raise level");

endmodule

`default_nettype wire

>>> rtl/urbq_stats.sv
`default_nettype none

module urbq_stats
    import urbq_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_stat_ev         i_ev,
    output logic [CNT_W-1:0]      o_drop_total,
    output logic [CNT_W-1:0]      o_rx_total,
    output logic [CNT_W-1:0]      o_tx_total
);

    logic [CNT_W-1:0] r_drop, r_rx, r_tx;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ev.clear) begin
            r_drop <= '0;
            r_rx   <= '0;
            r_tx   <= '0;
        end else begin
            if (i_ev.drop) r_drop <= sat_inc(r_drop);
            if (i_ev.rx)   r_rx   <= sat_inc(r_rx);
            if (i_ev.sent) r_tx   <= sat_inc(r_tx);
        end
    end

    assign o_drop_total = r_drop;
    assign o_rx_total   = r_rx;
    assign o_tx_total   = r_tx;

endmodule

`default_nettype wire

>>> rtl/uart_rx_tx_byte_queues.sv
`default_nettype none

// Buffered UART byte interface: a receive ring fed by the line and drained by
// application reads, and a transmit queue filled by application writes and
// drained by transmitter-ready events. Each input transfer carries an op in
// tuser (line byte, app read, app write, tx ready, clear statistics) and a
// byte in tdata; each produces exactly one output transfer reporting the
// outcome, both levels, the busy flag and three saturating counters. A ring
// of depth D holds D-1 bytes. Throughput is one transfer per cycle unless the
// output stalls; items pass the input, then the result register. The memory read for
// an item is issued as it is accepted, against the tail pointer it will see,
// so each ring needs a single registered read port; a byte written in that
// same cycle is forwarded. Back-pressure on the output stalls the input
// register only; one item can still be accepted while a result waits.
module uart_rx_tx_byte_queues
    import urbq_pkg::*;
#(
    parameter int unsigned RX_DEPTH = 256,
    parameter int unsigned TX_DEPTH = 256
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [7:0]             i_s_tdata,   // [7:0] data_byte
    input  wire logic [2:0]             i_s_tuser,   // [2:0] op
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // [0] accepted, [8:1] read_byte, [16:9] send_byte, [24:17] rx_level,
    // [32:25] tx_level, [33] tx_busy, [65:34] drop_total, [97:66] rx_total,
    // [129:98] tx_total, [135:130] zero
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    output logic [1:0]                  o_m_tuser    // [0] read_valid, [1] send_valid
);

    // input register
    logic              r_in_valid;
    logic [2:0]        r_in_op;
    logic [BYTE_W-1:0] r_in_data;

    // result register
    logic              r_out_valid;
    logic              r_accepted, r_read_valid, r_send_valid;
    logic [BYTE_W-1:0] r_read_byte, r_send_byte;
    logic              r_busy;

    logic              n_accepted, n_read_valid, n_send_valid, n_busy;
    logic [BYTE_W-1:0] n_read_byte, n_send_byte;

    logic              w_go, w_accept;
    t_op               w_op;
    t_ring_ctl         w_rx_ctl, w_tx_ctl;
    t_ring_sts         w_rx_sts, w_tx_sts;
    t_stat_ev          w_ev;
    logic [BYTE_W-1:0] w_rx_rd, w_tx_rd;
    logic [7:0]        w_rx_level, w_tx_level;
    logic [CNT_W-1:0]  w_drop_total, w_rx_total, w_tx_total;

    // item in the input register moves on when the result slot frees up
    assign w_go       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_go;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_op       = t_op'(r_in_op);

    always_comb begin
        w_rx_ctl     = '0;
        w_tx_ctl     = '0;
        w_ev         = '0;
        n_accepted   = 1'b0;
        n_read_valid = 1'b0;
        n_read_byte  = '0;
        n_send_valid = 1'b0;
        n_send_byte  = '0;
        n_busy       = r_busy;
        if (w_go) begin
            unique case (w_op)
                OP_RX_BYTE: begin
                    w_ev.rx       = 1'b1;
                    w_ev.drop     = w_rx_sts.full;
                    w_rx_ctl.push = !w_rx_sts.full;
                    n_accepted    = !w_rx_sts.full;
                end
                OP_APP_READ: begin
                    w_rx_ctl.pop = !w_rx_sts.empty;
                    n_read_valid = !w_rx_sts.empty;
                    n_read_byte  = w_rx_sts.empty ? '0 : w_rx_rd;
                end
                OP_APP_WRITE: begin
                    // full queue refuses, busy or not
                    w_tx_ctl.push = !w_tx_sts.full;
                    n_accepted    = !w_tx_sts.full;
                end
                OP_TX_READY: begin
                    w_tx_ctl.pop = !w_tx_sts.empty;
                    w_ev.sent    = !w_tx_sts.empty;
                    n_send_valid = !w_tx_sts.empty;
                    n_send_byte  = w_tx_sts.empty ? '0 : w_tx_rd;
                    n_busy       = !w_tx_sts.empty;
                end
                OP_CLR_STATS: begin
                    w_ev.clear = 1'b1;
                end
                default: begin
                    // unused codes only report status
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_busy      <= 1'b0;
        end else begin
            r_busy <= n_busy;
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_go) begin
                r_in_valid <= 1'b0;
            end
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_op   <= i_s_tuser;
            r_in_data <= i_s_tdata;
        end
        if (w_go) begin
            r_accepted   <= n_accepted;
            r_read_valid <= n_read_valid;
            r_read_byte  <= n_read_byte;
            r_send_valid <= n_send_valid;
            r_send_byte  <= n_send_byte;
        end
    end

    urbq_ring #(
        .DEPTH (RX_DEPTH)
    ) u_rx_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_ctl     (w_rx_ctl),
        .i_wr_data (r_in_data),
        .o_sts     (w_rx_sts),
        .o_rd_data (w_rx_rd),
        .o_level   (w_rx_level)
    );

    urbq_ring #(
        .DEPTH (TX_DEPTH)
    ) u_tx_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_ctl     (w_tx_ctl),
        .i_wr_data (r_in_data),
        .o_sts     (w_tx_sts),
        .o_rd_data (w_tx_rd),
        .o_level   (w_tx_level)
    );

    urbq_stats u_stats (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ev         (w_ev),
        .o_drop_total (w_drop_total),
        .o_rx_total   (w_rx_total),
        .o_tx_total   (w_tx_total)
    );

    // levels, busy and counters only move when a result is loaded, so they
    // stay aligned with the held result
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = {r_send_valid, r_read_valid};
    assign o_m_tdata  = {6'd0, w_tx_total, w_rx_total, w_drop_total, r_busy,
                         w_tx_level, w_rx_level, r_send_byte, r_read_byte,
                         r_accepted};

endmodule

`default_nettype wire

>>> tb/sv/tb_uart_rx_tx_byte_queues.sv
`timescale 1ns / 1ps

module tb_uart_rx_tx_byte_queues;
    import urbq_pkg::*;

    // Op codes the package leaves unnamed; the block must treat them as no-ops
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    localparam int N_DIRECTED   = 26;
    localparam int RANDOM_ITEMS = 1350;

    // One result transfer, split into its fields
    typedef struct packed {
        logic        accepted;
        logic        read_valid;
        logic [7:0]  read_byte;
        logic        send_valid;
        logic [7:0]  send_byte;
        logic [7:0]  rx_level;
        logic [7:0]  tx_level;
        logic        tx_busy;
        logic [31:0] drop_total;
        logic [31:0] rx_total;
        logic [31:0] tx_total;
    } t_q_status;

    // Directed stimulus row; lit holds a typed-in result when use_lit is set
    typedef struct {
        logic [2:0] op;
        logic [7:0] data;
        bit         use_lit;
        t_q_status  lit;
    } t_dir_row;

    // DUT ports
    logic                   i_clk      = 1'b0;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [7:0]             i_s_tdata  = '0;   // [7:0] data_byte
    logic [2:0]             i_s_tuser  = '0;   // [2:0] op
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // [0] accepted, [8:1] read_byte, [16:9] send_byte, [24:17] rx_level,
    // [32:25] tx_level, [33] tx_busy, [65:34] drop_total, [97:66] rx_total,
    // [129:98] tx_total, [135:130] zero
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic [1:0]             o_m_tuser;         // [0] read_valid, [1] send_valid

    uart_rx_tx_byte_queues dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predictor state: both rings at depth 256, so 8-bit pointers wrap on their own
    logic [7:0]  rx_mem [256];
    logic [7:0]  tx_mem [256];
    logic [7:0]  rx_wr_ptr = '0;
    logic [7:0]  rx_rd_ptr = '0;
    logic [7:0]  tx_wr_ptr = '0;
    logic [7:0]  tx_rd_ptr = '0;
    logic        tx_busy_q = 1'b0;
    logic [31:0] drop_cnt  = '0;
    logic [31:0] rx_cnt    = '0;
    logic [31:0] tx_cnt    = '0;

    t_q_status   status_fifo [$];     // expected results, oldest first
    int          fail_count   = 0;
    int          items_sent   = 0;
    int          results_seen = 0;
    int          burst_left   = 0;
    // what the run got into, for the summary
    int          n_rx_drops   = 0;
    int          n_tx_refused = 0;
    int          n_empty_rd   = 0;
    int          n_clears     = 0;

    function automatic logic [31:0] sat_add1(input logic [31:0] v);
        return (v == '1) ? v : v + 32'd1;
    endfunction

    function automatic t_q_status status_of(
        input logic acc, input logic rv, input logic [7:0] rb,
        input logic sv, input logic [7:0] sb, input logic [7:0] rl,
        input logic [7:0] tl, input logic busy, input logic [31:0] drops,
        input logic [31:0] rxs, input logic [31:0] txs);
        t_q_status s;
        s.accepted   = acc;
        s.read_valid = rv;
        s.read_byte  = rb;
        s.send_valid = sv;
        s.send_byte  = sb;
        s.rx_level   = rl;
        s.tx_level   = tl;
        s.tx_busy    = busy;
        s.drop_total = drops;
        s.rx_total   = rxs;
        s.tx_total   = txs;
        return s;
    endfunction

    // Advance the queue model by one op, return the status it should report
    function automatic t_q_status predict_queues(input logic [2:0] op, input logic [7:0] b);
        t_q_status  s;
        logic [7:0] nxt;
        s = '0;
        case (op)
            OP_RX_BYTE: begin
                nxt = rx_wr_ptr + 8'd1;
                if (nxt == rx_rd_ptr) begin
                    drop_cnt = sat_add1(drop_cnt);
                    n_rx_drops++;
                end else begin
                    rx_mem[rx_wr_ptr] = b;
                    rx_wr_ptr = nxt;
                    s.accepted = 1'b1;
                end
                rx_cnt = sat_add1(rx_cnt);
            end
            OP_APP_READ: begin
                if (rx_rd_ptr != rx_wr_ptr) begin
                    s.read_valid = 1'b1;
                    s.read_byte  = rx_mem[rx_rd_ptr];
                    rx_rd_ptr    = rx_rd_ptr + 8'd1;
                end else begin
                    n_empty_rd++;
                end
            end
            OP_APP_WRITE: begin
                nxt = tx_wr_ptr + 8'd1;
                // full queue always refuses, busy or not
                if (nxt != tx_rd_ptr) begin
                    tx_mem[tx_wr_ptr] = b;
                    tx_wr_ptr = nxt;
                    s.accepted = 1'b1;
                end else begin
                    n_tx_refused++;
                end
            end
            OP_TX_READY: begin
                if (tx_rd_ptr != tx_wr_ptr) begin
                    s.send_valid = 1'b1;
                    s.send_byte  = tx_mem[tx_rd_ptr];
                    tx_rd_ptr    = tx_rd_ptr + 8'd1;
                    tx_cnt       = sat_add1(tx_cnt);
                    tx_busy_q    = 1'b1;
                end else begin
                    tx_busy_q = 1'b0;
                end
            end
            OP_CLR_STATS: begin
                drop_cnt = '0;
                rx_cnt   = '0;
                tx_cnt   = '0;
                n_clears++;
            end
            default: ;  // spare codes: status only
        endcase
        s.rx_level   = rx_wr_ptr - rx_rd_ptr;
        s.tx_level   = tx_wr_ptr - tx_rd_ptr;
        s.tx_busy    = tx_busy_q;
        s.drop_total = drop_cnt;
        s.rx_total   = rx_cnt;
        s.tx_total   = tx_cnt;
        return s;
    endfunction

    // Sender: bursts of random length, random gaps between them. Valid stays
    // high across back-to-back transfers; it only drops for a gap.
    task automatic send_item(input logic [2:0] op, input logic [7:0] b,
                             input bit use_lit, input t_q_status lit);
        t_q_status pred;
        int        gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= op;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        // transfer taken at this edge
        pred = predict_queues(op, b);
        status_fifo.push_back(use_lit ? lit : pred);
        items_sent++;
    endtask

    // Random ops by percent weight; whatever is left over goes to clear / spare
    task automatic run_mix(input int n, input int w_rx, input int w_rd,
                           input int w_wr, input int w_tr);
        int         r;
        logic [2:0] op;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < w_rx)
                op = OP_RX_BYTE;
            else if (r < w_rx + w_rd)
                op = OP_APP_READ;
            else if (r < w_rx + w_rd + w_wr)
                op = OP_APP_WRITE;
            else if (r < w_rx + w_rd + w_wr + w_tr)
                op = OP_TX_READY;
            else if (r[0])
                op = OP_CLR_STATS;
            else
                op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            send_item(op, 8'($urandom), 1'b0, '0);
        end
    endtask

    // Receiver stall pattern, cycling through four modes: always ready, mostly
    // ready, ready a quarter of the time, alternating on/off blocks
    logic [7:0] stall_cyc = '0;
    always @(posedge i_clk) begin
        stall_cyc <= stall_cyc + 8'd1;
        case (stall_cyc[7:6])
            2'd0:    i_m_tready <= 1'b1;
            2'd1:    i_m_tready <= ($urandom_range(0, 3) != 0);
            2'd2:    i_m_tready <= (stall_cyc[1:0] == 2'd0);
            default: i_m_tready <= stall_cyc[3];
        endcase
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    // Result monitor: every output transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_q_status act;
        t_q_status want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            act.accepted   = o_m_tdata[0];
            act.read_byte  = o_m_tdata[8:1];
            act.send_byte  = o_m_tdata[16:9];
            act.rx_level   = o_m_tdata[24:17];
            act.tx_level   = o_m_tdata[32:25];
            act.tx_busy    = o_m_tdata[33];
            act.drop_total = o_m_tdata[65:34];
            act.rx_total   = o_m_tdata[97:66];
            act.tx_total   = o_m_tdata[129:98];
            act.read_valid = o_m_tuser[0];
            act.send_valid = o_m_tuser[1];
            results_seen++;
            if (status_fifo.size() == 0) begin
                $error("result transfer with nothing expected");
                fail_count++;
            end else begin
                want = status_fifo.pop_front();
                check_field("accepted",   32'(want.accepted),   32'(act.accepted));
                check_field("read_valid", 32'(want.read_valid), 32'(act.read_valid));
                check_field("read_byte",  32'(want.read_byte),  32'(act.read_byte));
                check_field("send_valid", 32'(want.send_valid), 32'(act.send_valid));
                check_field("send_byte",  32'(want.send_byte),  32'(act.send_byte));
                check_field("rx_level",   32'(want.rx_level),   32'(act.rx_level));
                check_field("tx_level",   32'(want.tx_level),   32'(act.tx_level));
                check_field("tx_busy",    32'(want.tx_busy),    32'(act.tx_busy));
                check_field("drop_total", want.drop_total,      act.drop_total);
                check_field("rx_total",   want.rx_total,        act.rx_total);
                check_field("tx_total",   want.tx_total,        act.tx_total);
            end
        end
    end

    // Main sequence
    initial begin
        t_dir_row dir_rows [N_DIRECTED];

        // empty reads / tx-ready / spare codes straight out of reset
        dir_rows[0]  = '{OP_APP_READ,  8'h00, 1'b1, status_of(0,0,8'h00,0,8'h00,0,0,0,0,0,0)};
        dir_rows[1]  = '{OP_TX_READY,  8'h00, 1'b1, status_of(0,0,8'h00,0,8'h00,0,0,0,0,0,0)};
        dir_rows[2]  = '{OP_SPARE_LO,  8'hFF, 1'b1, status_of(0,0,8'h00,0,8'h00,0,0,0,0,0,0)};
        dir_rows[3]  = '{OP_SPARE_MID, 8'h00, 1'b1, status_of(0,0,8'h00,0,8'h00,0,0,0,0,0,0)};
        dir_rows[4]  = '{OP_SPARE_HI,  8'hAA, 1'b1, status_of(0,0,8'h00,0,8'h00,0,0,0,0,0,0)};
        // extreme bytes through the receive ring, then read once too many
        dir_rows[5]  = '{OP_RX_BYTE,   8'h00, 1'b1, status_of(1,0,8'h00,0,8'h00,1,0,0,0,1,0)};
        dir_rows[6]  = '{OP_RX_BYTE,   8'hFF, 1'b1, status_of(1,0,8'h00,0,8'h00,2,0,0,0,2,0)};
        dir_rows[7]  = '{OP_APP_READ,  8'h00, 1'b1, status_of(0,1,8'h00,0,8'h00,1,0,0,0,2,0)};
        dir_rows[8]  = '{OP_APP_READ,  8'h00, 1'b1, status_of(0,1,8'hFF,0,8'h00,0,0,0,0,2,0)};
        dir_rows[9]  = '{OP_APP_READ,  8'h00, 1'b1, status_of(0,0,8'h00,0,8'h00,0,0,0,0,2,0)};
        // same through the transmit queue; last tx-ready finds it empty
        dir_rows[10] = '{OP_APP_WRITE, 8'hFF, 1'b1, status_of(1,0,8'h00,0,8'h00,0,1,0,0,2,0)};
        dir_rows[11] = '{OP_APP_WRITE, 8'h00, 1'b1, status_of(1,0,8'h00,0,8'h00,0,2,0,0,2,0)};
        dir_rows[12] = '{OP_TX_READY,  8'h00, 1'b1, status_of(0,0,8'h00,1,8'hFF,0,1,1,0,2,1)};
        dir_rows[13] = '{OP_TX_READY,  8'h00, 1'b1, status_of(0,0,8'h00,1,8'h00,0,0,1,0,2,2)};
        dir_rows[14] = '{OP_TX_READY,  8'h00, 1'b1, status_of(0,0,8'h00,0,8'h00,0,0,0,0,2,2)};
        dir_rows[15] = '{OP_CLR_STATS, 8'hFF, 1'b1, status_of(0,0,8'h00,0,8'h00,0,0,0,0,0,0)};
        // clear while busy, spare code with data in flight
        dir_rows[16] = '{OP_RX_BYTE,   8'h55, 1'b0, '0};
        dir_rows[17] = '{OP_RX_BYTE,   8'hAA, 1'b0, '0};
        dir_rows[18] = '{OP_APP_WRITE, 8'h80, 1'b0, '0};
        dir_rows[19] = '{OP_APP_WRITE, 8'h01, 1'b0, '0};
        dir_rows[20] = '{OP_TX_READY,  8'h00, 1'b0, '0};
        dir_rows[21] = '{OP_CLR_STATS, 8'h00, 1'b0, '0};
        dir_rows[22] = '{OP_APP_READ,  8'h00, 1'b0, '0};
        dir_rows[23] = '{OP_SPARE_HI,  8'h7F, 1'b0, '0};
        dir_rows[24] = '{OP_TX_READY,  8'h00, 1'b0, '0};
        dir_rows[25] = '{OP_TX_READY,  8'h00, 1'b0, '0};

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i])
            send_item(dir_rows[i].op, dir_rows[i].data, dir_rows[i].use_lit, dir_rows[i].lit);

        // flood the receive ring past full, then drain it past empty
        run_mix(265, 100, 0, 0, 0);
        run_mix(280, 5, 88, 2, 2);
        // flood the transmit queue with a few sends mixed in so busy is set at full
        run_mix(285, 0, 0, 97, 3);
        run_mix(280, 2, 2, 5, 88);
        // balanced traffic for the rest
        while (items_sent < RANDOM_ITEMS)
            run_mix($urandom_range(20, 80), 25, 20, 25, 20);

        i_s_tvalid <= 1'b0;
        while (status_fifo.size() != 0) @(posedge i_clk);
        // give stray results from the pipe room to show up
        repeat (8) @(posedge i_clk);

        $display("%0d transfers in, %0d results checked", items_sent, results_seen);
        $display("ring-full drops %0d, queue-full refusals %0d, empty reads %0d, clears %0d",
                 n_rx_drops, n_tx_refused, n_empty_rd, n_clears);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // Watchdog, well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> filelist.f
rtl/urbq_pkg.sv
rtl/urbq_ring.sv
rtl/urbq_stats.sv
rtl/uart_rx_tx_byte_queues.sv
tb/sv/tb_uart_rx_tx_byte_queues.sv
